// ===== rtl/core/hrs_pkg.sv =====
// ----------------------------------------------------------------------------
// hrs_pkg
// shared constants, codes and types of the hid report slot scheduler
// ----------------------------------------------------------------------------
package hrs_pkg;

   localparam int SLOT_BYTES = 32;
   localparam int NSLOTS     = 4;
   localparam int SLOT_W     = $clog2(NSLOTS);
   localparam int IDX_W      = $clog2(SLOT_BYTES);
   localparam int LEN_W      = $clog2(SLOT_BYTES + 1);
   localparam int CNT_W      = $clog2(SLOT_BYTES + 2);
   localparam int SLOT_AW    = $clog2(NSLOTS * SLOT_BYTES);
   localparam int CMD_W      = 3;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 16;
   localparam int INF_W      = 3;

   localparam logic [CMD_W-1:0] CMD_BYTE     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_COMPLETE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_TICK     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CONFIG   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DETACH   = 3'd4;

   localparam logic [CSR_AW-1:0] CSR_ID_KEYS     = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_ID_MOUSE    = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_ID_SYSTEM   = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_ID_CONSUMER = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_TIMEOUT     = 3'd4;

   localparam logic [SLOT_W-1:0] SLOT_KEYS     = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_MOUSE    = 2'd1;
   localparam logic [SLOT_W-1:0] SLOT_CONSUMER = 2'd2;
   localparam logic [SLOT_W-1:0] SLOT_SYSTEM   = 2'd3;

   localparam logic [INF_W-1:0] NO_SLOT = 3'd4;

   // last byte index of the mouse deltas
   localparam logic [LEN_W-1:0] MOUSE_LAST_IDX = LEN_W'(5);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ID_RD,
      ST_ID_CHK,
      ST_CMP_RD,
      ST_CMP_CHK,
      ST_CPY_RD,
      ST_CPY_WR,
      ST_MRG_RD,
      ST_MRG_WR,
      ST_PICK,
      ST_SND_RD,
      ST_SND_LD
   } state_type;

   typedef struct packed {
      logic [7:0]        data;
      logic              last;
      logic [SLOT_W-1:0] kind;
   } tx_item_type;

endpackage

// ===== rtl/core/hrs_ram.sv =====
// ----------------------------------------------------------------------------
// hrs_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module hrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/hrs_tx_reg.sv =====
// ----------------------------------------------------------------------------
// hrs_tx_reg
// output register of the result stream, holds a byte while the receiver stalls
// ----------------------------------------------------------------------------
module hrs_tx_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  hrs_pkg::tx_item_type item,
   output logic                can_load,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // tx_byte
   output logic                rsp_tlast,   // tx_last
   output logic [1:0]          rsp_tuser    // tx_kind
);
   import hrs_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   tx_item_type item_ff;

   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         item_ff <= item;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = item_ff.data;
   assign rsp_tlast  = item_ff.last;
   assign rsp_tuser  = item_ff.kind;

endmodule

// ===== rtl/core/hid_report_slot_scheduler.sv =====
// ----------------------------------------------------------------------------
// hid_report_slot_scheduler
// files hid reports into four slots and streams the chosen slot to the endpoint
// ----------------------------------------------------------------------------
// req channel: one request per event. tuser carries the command (report byte,
//   transfer complete, tick, configured, reset/disconnect), tdata the report
//   byte and tlast the end of a report. csr port writes the report ids and the
//   timeout at any idle time.
// rsp channel: the bytes of a sent report, tlast on the final one, tuser the
//   slot kind.
// a report byte without tlast, a quiet tick and a configure or reset event
//   are handled in the idle state; a completion or a timeout also passes
//   through the pick state. filing a report reads the staging ram and the
//   slot ram byte by byte: id lookup, compare per byte, copy per byte,
//   mouse merge per merged byte, then the pick state.
// a send reads each byte through the single read port of the slot ram, then
//   loads it; a stalled receiver holds the output register and the walk waits.
// requests are taken only while the controller is idle; the last sent byte
//   may still wait in the output register while the next request is taken.
// reset clears lengths, dirty marks, counters and flags; ram contents stay
//   undefined and are only read below a slot's written length.
// ----------------------------------------------------------------------------
module hid_report_slot_scheduler (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // data_byte
   input  logic                        req_tlast,   // last
   input  logic [hrs_pkg::CMD_W-1:0]   req_tuser,   // cmd
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,   // tx_byte
   output logic                        rsp_tlast,   // tx_last
   output logic [1:0]                  rsp_tuser,   // tx_kind
   input  logic                        csr_we,
   input  logic [hrs_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [hrs_pkg::CSR_DW-1:0]  csr_wdata
);
   import hrs_pkg::*;

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [LEN_W-1:0]  slen_ff [NSLOTS];
   logic [LEN_W-1:0]  slen_in [NSLOTS];
   logic [NSLOTS-1:0] dirty_ff, dirty_in;
   logic              up_ff, up_in;
   logic              busy_ff, busy_in;
   logic [INF_W-1:0]  infl_ff, infl_in;
   logic [15:0]       elapsed_ff, elapsed_in;
   logic [7:0]        id_keys_ff, id_mouse_ff, id_system_ff, id_consumer_ff;
   logic [15:0]       timeout_ff;

   logic              st_we, st_re;
   logic [IDX_W-1:0]  st_waddr, st_raddr;
   logic [7:0]        st_rdata;
   logic              sl_we, sl_re;
   logic [SLOT_AW-1:0] sl_waddr, sl_raddr;
   logic [7:0]        sl_wdata, sl_rdata;

   logic              tx_load, tx_can_load;
   tx_item_type       tx_item;

   logic              accept;
   logic [CNT_W-1:0]  cnt_next;
   logic [15:0]       elapsed_inc;
   logic [LEN_W-1:0]  last_idx;
   logic              pick_found;
   logic [SLOT_W-1:0] pick_slot;
   logic signed [8:0] sum;
   logic [7:0]        sat_byte;

   hrs_ram #(.WIDTH(8), .DEPTH(SLOT_BYTES)) u_stage_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (req_tdata),
      .rd_en   (st_re),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   hrs_ram #(.WIDTH(8), .DEPTH(NSLOTS * SLOT_BYTES)) u_slot_ram (
      .clock   (clock),
      .wr_en   (sl_we),
      .wr_addr (sl_waddr),
      .wr_data (sl_wdata),
      .rd_en   (sl_re),
      .rd_addr (sl_raddr),
      .rd_data (sl_rdata)
   );

   hrs_tx_reg u_tx_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (tx_load),
      .item       (tx_item),
      .can_load   (tx_can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign last_idx   = len_ff - LEN_W'(1);
   assign cnt_next   = (cnt_ff <= CNT_W'(SLOT_BYTES)) ? cnt_ff + CNT_W'(1) : cnt_ff;
   assign elapsed_inc = (elapsed_ff != 16'hFFFF) ? elapsed_ff + 16'd1 : elapsed_ff;

   // saturating add of one signed mouse delta
   always_comb begin
      sum = 9'(signed'(sl_rdata)) + 9'(signed'(st_rdata));
      if (sum > 9'sd127) begin
         sat_byte = 8'd127;
      end else if (sum < -9'sd127) begin
         sat_byte = 8'h81;
      end else begin
         sat_byte = sum[7:0];
      end
   end

   // highest priority dirty slot with a nonzero length, the lowest index wins
   always_comb begin
      pick_found = 1'b0;
      pick_slot  = SLOT_KEYS;
      for (int s = NSLOTS - 1; s >= 0; s--) begin
         if (dirty_ff[s] && (slen_ff[s] != '0)) begin
            pick_found = 1'b1;
            pick_slot  = SLOT_W'(s);
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      slot_in    = slot_ff;
      cnt_in     = cnt_ff;
      slen_in    = slen_ff;
      dirty_in   = dirty_ff;
      up_in      = up_ff;
      busy_in    = busy_ff;
      infl_in    = infl_ff;
      elapsed_in = elapsed_ff;
      st_we      = 1'b0;
      st_waddr   = cnt_ff[IDX_W-1:0];
      st_re      = 1'b0;
      st_raddr   = idx_ff[IDX_W-1:0];
      sl_we      = 1'b0;
      sl_waddr   = {slot_ff, idx_ff[IDX_W-1:0]};
      sl_wdata   = st_rdata;
      sl_re      = 1'b0;
      sl_raddr   = {slot_ff, idx_ff[IDX_W-1:0]};
      tx_load    = 1'b0;
      tx_item.data = sl_rdata;
      tx_item.last = (idx_ff == last_idx);
      tx_item.kind = slot_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  CMD_BYTE: begin
                     st_we = (cnt_ff < CNT_W'(SLOT_BYTES));
                     if (req_tlast) begin
                        cnt_in = '0;
                        if (cnt_next <= CNT_W'(SLOT_BYTES)) begin
                           len_in   = cnt_next[LEN_W-1:0];
                           state_in = ST_ID_RD;
                        end
                     end else begin
                        cnt_in = cnt_next;
                     end
                  end
                  CMD_COMPLETE: begin
                     busy_in  = 1'b0;
                     infl_in  = NO_SLOT;
                     state_in = ST_PICK;
                  end
                  CMD_TICK: begin
                     if (busy_ff) begin
                        elapsed_in = elapsed_inc;
                        if (elapsed_inc > timeout_ff) begin
                           busy_in = 1'b0;
                           // lost completion: resend unless it was the mouse
                           if ((infl_ff != NO_SLOT) &&
                               (infl_ff[SLOT_W-1:0] != SLOT_MOUSE) &&
                               (slen_ff[infl_ff[SLOT_W-1:0]] != '0)) begin
                              dirty_in[infl_ff[SLOT_W-1:0]] = 1'b1;
                           end
                           infl_in  = NO_SLOT;
                           state_in = ST_PICK;
                        end
                     end
                  end
                  CMD_CONFIG, CMD_DETACH: begin
                     up_in      = (req_tuser == CMD_CONFIG);
                     busy_in    = 1'b0;
                     infl_in    = NO_SLOT;
                     elapsed_in = '0;
                     dirty_in   = '0;
                     for (int s = 0; s < NSLOTS; s++) begin
                        slen_in[s] = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ID_RD: begin
            st_re    = 1'b1;
            st_raddr = '0;
            state_in = ST_ID_CHK;
         end
         ST_ID_CHK: begin
            idx_in = '0;
            if (st_rdata == id_keys_ff) begin
               slot_in = SLOT_KEYS;
            end else if (st_rdata == id_mouse_ff) begin
               slot_in = SLOT_MOUSE;
            end else if (st_rdata == id_consumer_ff) begin
               slot_in = SLOT_CONSUMER;
            end else begin
               slot_in = SLOT_SYSTEM;
            end
            if ((st_rdata != id_keys_ff) && (st_rdata != id_mouse_ff) &&
                (st_rdata != id_consumer_ff) && (st_rdata != id_system_ff)) begin
               state_in = ST_IDLE;
            end else if (slot_in == SLOT_MOUSE) begin
               if (dirty_ff[SLOT_MOUSE] && (slen_ff[SLOT_MOUSE] == len_ff)) begin
                  idx_in   = LEN_W'(1);
                  state_in = (len_ff > LEN_W'(1)) ? ST_MRG_RD : ST_PICK;
               end else begin
                  state_in = ST_CPY_RD;
               end
            end else if (slen_ff[slot_in] == len_ff) begin
               state_in = ST_CMP_RD;
            end else begin
               state_in = ST_CPY_RD;
            end
         end
         ST_CMP_RD: begin
            st_re    = 1'b1;
            sl_re    = 1'b1;
            state_in = ST_CMP_CHK;
         end
         ST_CMP_CHK: begin
            if (st_rdata != sl_rdata) begin
               idx_in   = '0;
               state_in = ST_CPY_RD;
            end else if (idx_ff == last_idx) begin
               state_in = ST_IDLE;  // identical report, dropped
            end else begin
               idx_in   = idx_ff + LEN_W'(1);
               state_in = ST_CMP_RD;
            end
         end
         ST_CPY_RD: begin
            st_re    = 1'b1;
            state_in = ST_CPY_WR;
         end
         ST_CPY_WR: begin
            sl_we = 1'b1;
            if (idx_ff == last_idx) begin
               slen_in[slot_ff]  = len_ff;
               dirty_in[slot_ff] = 1'b1;
               state_in          = ST_PICK;
            end else begin
               idx_in   = idx_ff + LEN_W'(1);
               state_in = ST_CPY_RD;
            end
         end
         ST_MRG_RD: begin
            st_re    = 1'b1;
            sl_re    = 1'b1;
            state_in = ST_MRG_WR;
         end
         ST_MRG_WR: begin
            sl_we    = 1'b1;
            // buttons byte is replaced, deltas are summed
            sl_wdata = (idx_ff == LEN_W'(1)) ? st_rdata : sat_byte;
            if ((idx_ff == last_idx) || (idx_ff == MOUSE_LAST_IDX)) begin
               state_in = ST_PICK;
            end else begin
               idx_in   = idx_ff + LEN_W'(1);
               state_in = ST_MRG_RD;
            end
         end
         ST_PICK: begin
            if (up_ff && !busy_ff && pick_found) begin
               busy_in             = 1'b1;
               elapsed_in          = '0;
               infl_in             = INF_W'(pick_slot);
               dirty_in[pick_slot] = 1'b0;
               slot_in             = pick_slot;
               idx_in              = '0;
               len_in              = slen_ff[pick_slot];
               state_in            = ST_SND_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SND_RD: begin
            sl_re    = 1'b1;
            state_in = ST_SND_LD;
         end
         ST_SND_LD: begin
            if (tx_can_load) begin
               tx_load = 1'b1;
               if (idx_ff == last_idx) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + LEN_W'(1);
                  state_in = ST_SND_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         dirty_ff       <= '0;
         up_ff          <= 1'b0;
         busy_ff        <= 1'b0;
         infl_ff        <= NO_SLOT;
         elapsed_ff     <= '0;
         id_keys_ff     <= 8'd1;
         id_mouse_ff    <= 8'd2;
         id_system_ff   <= 8'd3;
         id_consumer_ff <= 8'd4;
         timeout_ff     <= 16'd50;
         for (int s = 0; s < NSLOTS; s++) begin
            slen_ff[s] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         dirty_ff   <= dirty_in;
         up_ff      <= up_in;
         busy_ff    <= busy_in;
         infl_ff    <= infl_in;
         elapsed_ff <= elapsed_in;
         slen_ff    <= slen_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_ID_KEYS:     id_keys_ff     <= csr_wdata[7:0];
               CSR_ID_MOUSE:    id_mouse_ff    <= csr_wdata[7:0];
               CSR_ID_SYSTEM:   id_system_ff   <= csr_wdata[7:0];
               CSR_ID_CONSUMER: id_consumer_ff <= csr_wdata[7:0];
               CSR_TIMEOUT:     timeout_ff     <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      len_ff  <= len_in;
      idx_ff  <= idx_in;
      slot_ff <= slot_in;
   end

endmodule
